/* design/sif_pkg.sv */
// shared types and constants for the symmetric index fold block
package sif_pkg;

    localparam int RANK        = 4;
    localparam int INDEX_WIDTH = 16;
    localparam int COUNT_WIDTH = 3;
    localparam int ADDR_WIDTH  = 3;
    localparam int DATA_WIDTH  = 32;

    // register indexes (byte address is index times four)
    localparam int unsigned REG_SAME_GROUP_MASK = 0;

    typedef logic [INDEX_WIDTH-1:0] t_index;
    typedef logic [RANK-1:0]        t_group_mask;
    typedef t_index                 t_index_vec [RANK];

    typedef struct packed {
        t_index                 index_0;
        t_index                 index_1;
        t_index                 index_2;
        t_index                 index_3;
        logic [COUNT_WIDTH-1:0] index_count;
    } t_request;

    typedef struct packed {
        t_index local_0;
        t_index local_1;
        t_index local_2;
        t_index local_3;
    } t_result;

endpackage

/* design/sif_apb_regs.sv */
// apb configuration register holding the same-group mask
module sif_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sif_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [sif_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [sif_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready,
    output sif_pkg::t_group_mask                o_mask
);

    sif_pkg::t_group_mask r_mask;
    sif_pkg::t_group_mask n_mask;
    logic [sif_pkg::ADDR_WIDTH-3:0] reg_index;
    logic wr_en;

    // low two address bits select bytes inside a word and are ignored
    assign reg_index = paddr[sif_pkg::ADDR_WIDTH-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_comb begin
        n_mask = r_mask;
        if (wr_en && (reg_index == (sif_pkg::ADDR_WIDTH-2)'(sif_pkg::REG_SAME_GROUP_MASK))) begin
            n_mask = pwdata[sif_pkg::RANK-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == (sif_pkg::ADDR_WIDTH-2)'(sif_pkg::REG_SAME_GROUP_MASK)) begin
            prdata[sif_pkg::RANK-1:0] = r_mask;
        end
    end

    assign o_mask = r_mask;

endmodule

/* design/sif_fold_core.sv */
// group-wise sort and difference of one index tuple, combinational
module sif_fold_core (
    input  sif_pkg::t_request    i_request,
    input  sif_pkg::t_group_mask i_mask,
    output sif_pkg::t_result     o_result
);

    sif_pkg::t_index_vec             raw;
    sif_pkg::t_index_vec             srt;
    sif_pkg::t_index_vec             loc;
    logic [sif_pkg::RANK-1:0]        used;
    logic [sif_pkg::RANK-1:0]        joins;
    logic [sif_pkg::COUNT_WIDTH-1:0] count_sat;
    sif_pkg::t_index                 tmp;

    assign raw[0] = i_request.index_0;
    assign raw[1] = i_request.index_1;
    assign raw[2] = i_request.index_2;
    assign raw[3] = i_request.index_3;

    // count saturates at the rank
    assign count_sat = (i_request.index_count > sif_pkg::COUNT_WIDTH'(sif_pkg::RANK))
                     ? sif_pkg::COUNT_WIDTH'(sif_pkg::RANK) : i_request.index_count;

    always_comb begin
        for (int d = 0; d < sif_pkg::RANK; d++) begin
            used[d] = (sif_pkg::COUNT_WIDTH'(d) < count_sat);
        end
        joins[0] = 1'b0;
        for (int d = 1; d < sif_pkg::RANK; d++) begin
            joins[d] = i_mask[d] && used[d];
        end
    end

    // odd-even transposition sort, comparators across a group edge disabled
    always_comb begin
        tmp = '0;
        for (int d = 0; d < sif_pkg::RANK; d++) begin
            srt[d] = used[d] ? raw[d] : '0;
        end
        for (int r = 0; r < sif_pkg::RANK; r++) begin
            for (int a = r % 2; a + 1 < sif_pkg::RANK; a += 2) begin
                if (joins[a+1] && (srt[a] > srt[a+1])) begin
                    tmp      = srt[a];
                    srt[a]   = srt[a+1];
                    srt[a+1] = tmp;
                end
            end
        end
    end

    always_comb begin
        loc[0] = used[0] ? srt[0] : '0;
        for (int d = 1; d < sif_pkg::RANK; d++) begin
            if (!used[d]) begin
                loc[d] = '0;
            end else if (joins[d]) begin
                loc[d] = srt[d] - srt[d-1];
            end else begin
                loc[d] = srt[d];
            end
        end
    end

    assign o_result.local_0 = loc[0];
    assign o_result.local_1 = loc[1];
    assign o_result.local_2 = loc[2];
    assign o_result.local_3 = loc[3];

endmodule

/* design/symmetric_index_fold_top.sv */
// an accepted request passes from the request register through the sort network into the result register and o_done
// throughput: one request per cycle; busy is never raised, set by the single
//   registered pass from the request register through the sort network to the result register
// reset: synchronous active-low i_rst_n clears the group mask and both valid flags
// results are shown for one cycle only; the receiver cannot stall
module symmetric_index_fold_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sif_pkg::t_request               i_request,
    output logic                            o_done,
    output sif_pkg::t_result                o_result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sif_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [sif_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [sif_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready
);

    sif_pkg::t_group_mask mask;
    sif_pkg::t_request    r_req;
    logic                 r_req_valid;
    sif_pkg::t_result     fold_result;
    sif_pkg::t_result     r_result;
    logic                 r_done;

    sif_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mask  (mask)
    );

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_req_valid <= start && !busy;
            r_done      <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_request;
        end
        r_result <= fold_result;
    end

    sif_fold_core u_core (
        .i_request (r_req),
        .i_mask    (mask),
        .o_result  (fold_result)
    );

    assign o_done   = r_done;
    assign o_result = r_result;

    // every result traces back to an accepted request, through r_req_valid and r_done
    a_done_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, 2))
        else $error("result without a request");

    // a registered request always yields a result next cycle
    a_request_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_valid |=> o_done)
        else $error("request dropped");

    // last dimension reads zero when the count leaves it unused
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_request.index_count, 2) < 3'd4)) |-> (o_result.local_3 == '0))
        else $error("unused dimension not zero");

    // the group mask moves only on a register write
    a_mask_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(psel && penable && pwrite) |=> $stable(mask))
        else $error("group mask changed without a write");

endmodule

/* tb/sv/tb_symmetric_index_fold_top.sv */
// testbench for symmetric_index_fold_top: random and directed index tuples checked against a fold predictor
`timescale 1ns / 100ps

module tb_symmetric_index_fold_top;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    sif_pkg::t_request              i_request = '0;
    logic                           o_done;
    sif_pkg::t_result               o_result;
    logic                           psel = 1'b0;
    logic                           penable = 1'b0;
    logic                           pwrite = 1'b0;
    logic [sif_pkg::ADDR_WIDTH-1:0] paddr = '0;
    logic [sif_pkg::DATA_WIDTH-1:0] pwdata = '0;
    logic [sif_pkg::DATA_WIDTH-1:0] prdata;
    logic                           pready;

    sif_pkg::t_request    pending_requests [$];
    sif_pkg::t_result     expected_locals [$];
    sif_pkg::t_result     expected_local;
    sif_pkg::t_group_mask group_mask_model = '0;
    int                   send_idle_pct = 0;
    int                   mismatch_count = 0;

    symmetric_index_fold_top u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_request (i_request),
        .o_done    (o_done),
        .o_result  (o_result),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 i_clk = ~i_clk;

    function automatic bit joins_group(sif_pkg::t_group_mask mask, int dim);
        return dim > 0 && dim < sif_pkg::RANK && mask[dim];
    endfunction

    // sort each symmetry group among the used indices, then difference within the group
    function automatic sif_pkg::t_result fold_request(sif_pkg::t_group_mask mask,
                                                      sif_pkg::t_request req);
        sif_pkg::t_index  vals [sif_pkg::RANK];
        sif_pkg::t_index  locs [sif_pkg::RANK];
        sif_pkg::t_index  key;
        int               used;
        int               lo;
        int               d;
        int               a;
        int               b;
        sif_pkg::t_result res;
        used = (int'(req.index_count) > sif_pkg::RANK) ? sif_pkg::RANK
                                                       : int'(req.index_count);
        vals[0] = req.index_0;
        vals[1] = req.index_1;
        vals[2] = req.index_2;
        vals[3] = req.index_3;
        for (d = 0; d < sif_pkg::RANK; d++) begin
            if (d >= used) begin
                vals[d] = '0;
            end
        end
        lo = 0;
        for (d = 1; d <= used; d++) begin
            if (d == used || !joins_group(mask, d)) begin
                for (a = lo + 1; a < d; a++) begin
                    key = vals[a];
                    b = a;
                    while (b > lo && vals[b-1] > key) begin
                        vals[b] = vals[b-1];
                        b--;
                    end
                    vals[b] = key;
                end
                lo = d;
            end
        end
        for (d = 0; d < sif_pkg::RANK; d++) begin
            if (d >= used) begin
                locs[d] = '0;
            end else if (joins_group(mask, d)) begin
                locs[d] = vals[d] - vals[d-1];
            end else begin
                locs[d] = vals[d];
            end
        end
        res.local_0 = locs[0];
        res.local_1 = locs[1];
        res.local_2 = locs[2];
        res.local_3 = locs[3];
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_local(input string field, input sif_pkg::t_index got,
                               input sif_pkg::t_index want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", field, got, want));
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_locals.push_back(fold_request(group_mask_model, i_request));
            end
            // a request held against busy stays on the port
            if (!(start && busy)) begin
                if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    start <= 1'b1;
                    i_request <= pending_requests.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_locals.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                expected_local = expected_locals.pop_front();
                check_local("local_0", o_result.local_0, expected_local.local_0);
                check_local("local_1", o_result.local_1, expected_local.local_1);
                check_local("local_2", o_result.local_2, expected_local.local_2);
                check_local("local_3", o_result.local_3, expected_local.local_3);
            end
        end
    end

    task automatic apb_access(input bit is_write,
                              input logic [sif_pkg::DATA_WIDTH-1:0] wdata,
                              output logic [sif_pkg::DATA_WIDTH-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= sif_pkg::ADDR_WIDTH'(sif_pkg::REG_SAME_GROUP_MASK * 4);
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (is_write) begin
            group_mask_model = sif_pkg::t_group_mask'(wdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_mask_readback();
        logic [sif_pkg::DATA_WIDTH-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== sif_pkg::DATA_WIDTH'(group_mask_model)) begin
            report_mismatch($sformatf("group mask read %h want %h", rd, group_mask_model));
        end
    endtask

    task automatic write_group_mask(input sif_pkg::t_group_mask mask);
        logic [sif_pkg::DATA_WIDTH-1:0] rd;
        apb_access(1'b1, sif_pkg::DATA_WIDTH'(mask), rd);
        check_mask_readback();
    endtask

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_requests.size() != 0 || start || expected_locals.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic queue_request(input sif_pkg::t_index i0, input sif_pkg::t_index i1,
                                 input sif_pkg::t_index i2, input sif_pkg::t_index i3,
                                 input logic [sif_pkg::COUNT_WIDTH-1:0] cnt);
        sif_pkg::t_request req;
        req.index_0     = i0;
        req.index_1     = i1;
        req.index_2     = i2;
        req.index_3     = i3;
        req.index_count = cnt;
        pending_requests.push_back(req);
    endtask

    // lean toward small and near-max values so equal indices and wrap show up
    function automatic sif_pkg::t_index pick_index();
        case ($urandom_range(0, 3))
            1:       return sif_pkg::t_index'($urandom_range(0, 3));
            2:       return 16'hFFFF - sif_pkg::t_index'($urandom_range(0, 3));
            default: return sif_pkg::t_index'($urandom_range(0, 65535));
        endcase
    endfunction

    initial begin
        int phase;
        int k;
        logic [sif_pkg::COUNT_WIDTH-1:0] cnt;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();
        check_mask_readback();

        // directed: reset mask means every dimension is its own group
        @(negedge i_clk);
        queue_request(16'd4, 16'd3, 16'd2, 16'd1, 3'd4);
        queue_request(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 3'd4);
        wait_idle();

        // one group spanning all dimensions
        write_group_mask(4'hF);
        @(negedge i_clk);
        queue_request(16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd4);
        queue_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd4);
        queue_request(16'd4, 16'd3, 16'd2, 16'd1, 3'd4);
        queue_request(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 3'd4);
        queue_request(16'd7, 16'd7, 16'd7, 16'd7, 3'd4);
        queue_request(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 3'd0);
        queue_request(16'h9000, 16'h0005, 16'h8000, 16'h0001, 3'd5);
        queue_request(16'hAAAA, 16'h5555, 16'h0001, 16'hFFFE, 3'd6);
        queue_request(16'h0003, 16'h0002, 16'h0001, 16'h0000, 3'd7);
        queue_request(16'd30, 16'd20, 16'd10, 16'd5, 3'd1);
        queue_request(16'd30, 16'd20, 16'd10, 16'd5, 3'd2);
        queue_request(16'd30, 16'd20, 16'd10, 16'd5, 3'd3);
        wait_idle();

        // two groups of two, then a group cut short by the count
        write_group_mask(4'b1010);
        @(negedge i_clk);
        queue_request(16'd9, 16'd2, 16'd8, 16'd3, 3'd4);
        queue_request(16'd9, 16'd2, 16'd8, 16'd3, 3'd3);
        queue_request(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 3'd4);
        wait_idle();
        write_group_mask(4'b0101);
        @(negedge i_clk);
        queue_request(16'd50, 16'd40, 16'd30, 16'd20, 3'd4);
        queue_request(16'd1, 16'd6, 16'd6, 16'd0, 3'd3);
        wait_idle();

        // random phases: mask settings crossed with sender idling
        for (phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                write_group_mask(4'h0);
            end else if (phase == 1) begin
                write_group_mask(4'hF);
            end else begin
                write_group_mask(sif_pkg::t_group_mask'($urandom_range(0, 15)));
            end
            @(negedge i_clk);
            case (phase % 4)
                1:       send_idle_pct = 50;
                3:       send_idle_pct = 37;
                default: send_idle_pct = 0;
            endcase
            for (k = 0; k < 50; k++) begin
                cnt = ($urandom_range(0, 2) == 0)
                    ? sif_pkg::COUNT_WIDTH'($urandom_range(0, 7))
                    : sif_pkg::COUNT_WIDTH'(sif_pkg::RANK);
                queue_request(pick_index(), pick_index(), pick_index(), pick_index(), cnt);
            end
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("tb_symmetric_index_fold_top: PASS");
        end else begin
            $display("tb_symmetric_index_fold_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_symmetric_index_fold_top: FAIL");
        $finish;
    end

endmodule
